// ----- rtl/adl_pkg.sv -----
// ----------------------------------------------------------------------------
// adl_pkg
// Shared constants, the calibration rom and the code helper for the infrared
// distance linearizer.
// ----------------------------------------------------------------------------
package adl_pkg;

  // table geometry and field widths
  localparam int unsigned ADL_ENTRIES     = 16;
  localparam int unsigned ADL_IDX_BITS    = $clog2(ADL_ENTRIES);
  localparam int unsigned ADL_SAMPLE_BITS = 10;
  localparam int unsigned ADL_DIST_BITS   = 9;
  localparam int unsigned ADL_REF_MV      = 3300;

  // sensor calibration points, voltage in mV, descending
  localparam int unsigned ADL_MV_TABLE [ADL_ENTRIES] = '{
    2860, 2770, 2340, 1950, 1680, 1470, 1320, 1170,
    980,  810,  710,  600,  520,  460,  410,  310
  };

  // matching distances in mm
  localparam logic [ADL_DIST_BITS-1:0] ADL_MM_TABLE [ADL_ENTRIES] = '{
    9'd30,  9'd40,  9'd50,  9'd60,  9'd70,  9'd80,  9'd90,  9'd100,
    9'd120, 9'd140, 9'd160, 9'd180, 9'd200, 9'd220, 9'd250, 9'd300
  };

  // adc code of a calibration point, truncated, for a given converter width
  function automatic int unsigned adl_code(input int unsigned sample_bits,
                                           input int unsigned idx);
    int unsigned full;
    full = (32'd1 << sample_bits) - 32'd1;
    return (ADL_MV_TABLE[idx] * full) / ADL_REF_MV;
  endfunction

endpackage

// ----- rtl/adc_distance_linearizer_top.sv -----
// ----------------------------------------------------------------------------
// adc_distance_linearizer_top
// Converts a raw infrared range sensor sample into millimetres by a serial
// search of a calibration rom and linear interpolation inside the segment.
// ----------------------------------------------------------------------------
// Usage
//   in_valid/in_sample/in_stall carry one adc sample per item; out_valid,
//   out_distance_mm and out_out_of_range carry one result per item, and the
//   receiver holds it with out_stall. Every item gives exactly one result.
//   A sample above the nearest calibration code reads 30 mm; one at or below
//   the farthest code raises out_of_range with distance 0.
// Timing
//   The rom is scanned one entry a cycle by a single comparator. An
//   interpolated item then passes the multiply state and 9 restoring
//   divide steps through one shared subtractor before its result is loaded
//   into the output register; a saturated or out of range item goes from
//   the search straight to that load, after which the sequencer returns to
//   idle and takes the next item.
//   in_stall is high from accept until the result reaches the output
//   register; a result still waiting there does not block the next sample.
// Reset and stall
//   rst_n (synchronous, active low) drops any item in flight and clears
//   out_valid. While out_stall holds, the output register keeps its item and
//   a finished result waits in the sequencer until the register frees up.
// ----------------------------------------------------------------------------
module adc_distance_linearizer_top
  import adl_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = ADL_SAMPLE_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [SAMPLE_BITS-1:0]   in_sample,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [ADL_DIST_BITS-1:0] out_distance_mm,
  output logic                     out_out_of_range
);

  localparam int unsigned SB = SAMPLE_BITS;
  localparam int unsigned DW = ADL_DIST_BITS;
  localparam int unsigned IW = ADL_IDX_BITS;
  localparam int unsigned PW = SB + DW;
  localparam int unsigned CW = $clog2(DW);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SEARCH = 5'b00010,
    S_MUL    = 5'b00100,
    S_DIV    = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  // calibration codes for this converter width
  logic [SB-1:0] code_tab [ADL_ENTRIES];
  for (genvar g = 0; g < ADL_ENTRIES; g++) begin : g_code
    assign code_tab[g] = SB'(adl_code(SB, g));
  end

  state_t         state_r, state_nxt;
  logic [SB-1:0]  sample_r, sample_nxt;
  logic [IW-1:0]  idx_r, idx_nxt;
  logic [SB-1:0]  rem_r, rem_nxt;
  logic [DW-1:0]  lo_r, lo_nxt;
  logic [DW-1:0]  quot_r, quot_nxt;
  logic [SB-1:0]  vd_r, vd_nxt;
  logic [DW-1:0]  d0_r, d0_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [DW-1:0]  res_dist_r, res_dist_nxt;
  logic           res_oor_r, res_oor_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [DW-1:0]  out_dist_r, out_dist_nxt;
  logic           out_oor_r, out_oor_nxt;

  // segment operands and the shared datapath
  logic [IW-1:0]  idx_prev;
  logic [SB-1:0]  seg_c0;
  logic [SB-1:0]  seg_span;
  logic [DW-1:0]  seg_dd;
  logic [PW-1:0]  prod;
  logic [SB:0]    trial;
  logic [SB:0]    trial_diff;
  logic           trial_ok;
  logic [DW-1:0]  quot_step;

  assign idx_prev   = idx_r - IW'(1);
  assign seg_c0     = code_tab[idx_prev];
  assign seg_span   = seg_c0 - sample_r;
  assign seg_dd     = ADL_MM_TABLE[idx_r] - ADL_MM_TABLE[idx_prev];
  assign prod       = PW'(seg_span) * PW'(seg_dd);
  assign trial      = {rem_r, lo_r[DW-1]};
  assign trial_diff = trial - {1'b0, vd_r};
  assign trial_ok   = (trial >= {1'b0, vd_r});
  assign quot_step  = {quot_r[DW-2:0], trial_ok};

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    sample_nxt    = sample_r;
    idx_nxt       = idx_r;
    rem_nxt       = rem_r;
    lo_nxt        = lo_r;
    quot_nxt      = quot_r;
    vd_nxt        = vd_r;
    d0_nxt        = d0_r;
    cnt_nxt       = cnt_r;
    res_dist_nxt  = res_dist_r;
    res_oor_nxt   = res_oor_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_dist_nxt  = out_dist_r;
    out_oor_nxt   = out_oor_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          sample_nxt = in_sample;
          idx_nxt    = '0;
          state_nxt  = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (sample_r > code_tab[idx_r]) begin
          if (idx_r == '0) begin
            res_dist_nxt = ADL_MM_TABLE[0];
            res_oor_nxt  = 1'b0;
            state_nxt    = S_DONE;
          end else begin
            state_nxt = S_MUL;
          end
        end else if (idx_r == IW'(ADL_ENTRIES - 1)) begin
          res_dist_nxt = '0;
          res_oor_nxt  = 1'b1;
          state_nxt    = S_DONE;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end
      S_MUL: begin
        rem_nxt   = prod[PW-1:DW];
        lo_nxt    = prod[DW-1:0];
        vd_nxt    = seg_c0 - code_tab[idx_r];
        d0_nxt    = ADL_MM_TABLE[idx_prev];
        quot_nxt  = '0;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        rem_nxt  = trial_ok ? trial_diff[SB-1:0] : trial[SB-1:0];
        lo_nxt   = {lo_r[DW-2:0], 1'b0};
        quot_nxt = quot_step;
        cnt_nxt  = cnt_r + CW'(1);
        if (cnt_r == CW'(DW - 1)) begin
          // flat segment keeps the start distance
          res_dist_nxt = (vd_r == '0) ? d0_r : d0_r + quot_step;
          res_oor_nxt  = 1'b0;
          state_nxt    = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_dist_nxt  = res_dist_r;
          out_oor_nxt   = res_oor_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    sample_r   <= sample_nxt;
    idx_r      <= idx_nxt;
    rem_r      <= rem_nxt;
    lo_r       <= lo_nxt;
    quot_r     <= quot_nxt;
    vd_r       <= vd_nxt;
    d0_r       <= d0_nxt;
    cnt_r      <= cnt_nxt;
    res_dist_r <= res_dist_nxt;
    res_oor_r  <= res_oor_nxt;
    out_dist_r <= out_dist_nxt;
    out_oor_r  <= out_oor_nxt;
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_distance_mm  = out_dist_r;
  assign out_out_of_range = out_oor_r;

`ifndef SYNTH
  // an accepted sample always starts a table scan
  a_accept_starts_search: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_SEARCH))
    else $error("accepted item did not start the search");

  // restoring divide keeps the partial remainder below the divisor
  a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < vd_r))
    else $error("partial remainder not below segment span");

  // out of range results carry a zero distance
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_out_of_range) |-> (out_distance_mm == '0))
    else $error("out of range item with nonzero distance");

  // in range results stay within the calibrated span
  a_dist_span: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_out_of_range) |->
      (out_distance_mm >= ADL_MM_TABLE[0]) &&
      (out_distance_mm <= ADL_MM_TABLE[ADL_ENTRIES-1]))
    else $error("distance outside calibrated span");
`endif

endmodule

// ----- tb/adc_distance_linearizer_top_tb.sv -----
// ----------------------------------------------------------------------------
// adc_distance_linearizer_top_tb
// Self-checking bench for the infrared distance linearizer. A directed sweep
// over the calibration codes and the range limits is followed by random
// samples biased towards the interpolated segments. Each accepted sample's expected
// distance and range flag, typed in or predicted here, is checked against
// the result stream, with random sender bursts and receiver back-pressure.
// ----------------------------------------------------------------------------
module adc_distance_linearizer_top_tb
  import adl_pkg::*;
();

  localparam int unsigned FULL_CODE    = (1 << ADL_SAMPLE_BITS) - 1;
  localparam int unsigned SUPPLY_MV    = 3300;
  localparam int unsigned RANDOM_ITEMS = 1050;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned PROBE_COUNT  = 25;
  localparam int unsigned REPORT_LIMIT = 10;

  // calibration points of the sensor, voltage in mV and distance in mm
  localparam int unsigned CAL_MV [ADL_ENTRIES] = '{
    2860, 2770, 2340, 1950, 1680, 1470, 1320, 1170,
    980,  810,  710,  600,  520,  460,  410,  310
  };
  localparam int unsigned CAL_MM [ADL_ENTRIES] = '{
    30,  40,  50,  60,  70,  80,  90,  100,
    120, 140, 160, 180, 200, 220, 250, 300
  };

  typedef struct packed {
    logic [ADL_DIST_BITS-1:0] dist_mm;
    logic                     oor;
  } range_result_t;

  // one directed item; fixed marks a row whose result is typed in
  typedef struct packed {
    logic [ADL_SAMPLE_BITS-1:0] sample;
    logic                       fixed;
    logic [ADL_DIST_BITS-1:0]   dist_mm;
    logic                       oor;
  } probe_row_t;

  localparam probe_row_t PROBE_ROWS [PROBE_COUNT] = '{
    '{10'd0,    1'b1, 9'd0,   1'b1},  // bottom of the scale, too far
    '{10'd1023, 1'b1, 9'd30,  1'b0},  // full scale, near saturation
    '{10'd887,  1'b1, 9'd30,  1'b0},  // just above the nearest code
    '{10'd886,  1'b1, 9'd30,  1'b0},  // nearest code itself
    '{10'd858,  1'b1, 9'd40,  1'b0},
    '{10'd725,  1'b1, 9'd50,  1'b0},
    '{10'd604,  1'b1, 9'd60,  1'b0},
    '{10'd520,  1'b1, 9'd70,  1'b0},
    '{10'd455,  1'b1, 9'd80,  1'b0},
    '{10'd409,  1'b1, 9'd90,  1'b0},
    '{10'd362,  1'b1, 9'd100, 1'b0},
    '{10'd303,  1'b1, 9'd120, 1'b0},
    '{10'd251,  1'b1, 9'd140, 1'b0},
    '{10'd220,  1'b1, 9'd160, 1'b0},
    '{10'd186,  1'b1, 9'd180, 1'b0},
    '{10'd161,  1'b1, 9'd200, 1'b0},
    '{10'd142,  1'b1, 9'd220, 1'b0},
    '{10'd127,  1'b1, 9'd250, 1'b0},
    '{10'd96,   1'b1, 9'd0,   1'b1},  // farthest code, out of range
    '{10'd97,   1'b0, 9'd0,   1'b0},  // one above the farthest code
    '{10'd1,    1'b1, 9'd0,   1'b1},
    '{10'd512,  1'b0, 9'd0,   1'b0},
    '{10'd341,  1'b0, 9'd0,   1'b0},
    '{10'd682,  1'b0, 9'd0,   1'b0},
    '{10'd872,  1'b0, 9'd0,   1'b0}
  };

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_HEAVY
  } stall_mode_t;

  logic                       clk              = 1'b0;
  logic                       rst_n            = 1'b0;
  logic                       in_valid         = 1'b0;
  logic [ADL_SAMPLE_BITS-1:0] in_sample        = '0;
  logic                       out_stall        = 1'b0;
  logic                       in_stall;
  logic                       out_valid;
  logic [ADL_DIST_BITS-1:0]   out_distance_mm;
  logic                       out_out_of_range;

  range_result_t pending_ranges [$];
  int unsigned   fail_count     = 0;
  int unsigned   cycle_count    = 0;
  int unsigned   sent_count     = 0;
  int unsigned   near_count     = 0;
  int unsigned   far_count      = 0;
  int unsigned   interp_count   = 0;
  int unsigned   burst_left     = 0;
  stall_mode_t   stall_mode     = STALL_NONE;
  int unsigned   stall_left     = 0;
  int unsigned   stall_phase    = 0;

  adc_distance_linearizer_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_distance_mm  (out_distance_mm),
    .out_out_of_range (out_out_of_range)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // adc code of a calibration point, truncated
  function automatic int unsigned cal_code(input int unsigned idx);
    return (CAL_MV[idx] * FULL_CODE) / SUPPLY_MV;
  endfunction

  // expected distance and range flag for one sample
  function automatic range_result_t predict_range(input logic [ADL_SAMPLE_BITS-1:0] s);
    int unsigned   k;
    int unsigned   c0;
    int unsigned   c1;
    int unsigned   d0;
    int unsigned   d1;
    range_result_t r;
    k = 0;
    while (k < ADL_ENTRIES && !(s > cal_code(k)))
      k++;
    r.oor = 1'b0;
    if (k == 0) begin
      r.dist_mm = ADL_DIST_BITS'(CAL_MM[0]);
    end else if (k >= ADL_ENTRIES) begin
      r.oor     = 1'b1;
      r.dist_mm = '0;
    end else begin
      c0 = cal_code(k - 1);
      c1 = cal_code(k);
      d0 = CAL_MM[k - 1];
      d1 = CAL_MM[k];
      // a flat segment would keep its start distance
      if (c0 == c1)
        r.dist_mm = ADL_DIST_BITS'(d0);
      else
        r.dist_mm = ADL_DIST_BITS'(d0 + ((c0 - s) * (d1 - d0)) / (c0 - c1));
    end
    return r;
  endfunction

  // random sample, mostly inside the interpolated range
  function automatic logic [ADL_SAMPLE_BITS-1:0] pick_sample();
    int unsigned choice;
    int unsigned code;
    choice = $urandom_range(0, 9);
    if (choice < 5) begin
      return ADL_SAMPLE_BITS'($urandom_range(0, FULL_CODE));
    end else if (choice < 8) begin
      return ADL_SAMPLE_BITS'($urandom_range(cal_code(ADL_ENTRIES - 1), cal_code(0) + 1));
    end else if (choice == 8) begin
      code = cal_code($urandom_range(0, ADL_ENTRIES - 1));
      return ADL_SAMPLE_BITS'(code + $urandom_range(0, 2) - 1);
    end else begin
      if ($urandom_range(0, 1) == 1)
        return ADL_SAMPLE_BITS'(FULL_CODE - $urandom_range(0, 3));
      else
        return ADL_SAMPLE_BITS'($urandom_range(0, 3));
    end
  endfunction

  // sender bursts with random gaps, some bursts back to back
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 8);
        in_valid  <= 1'b0;
        in_sample <= ADL_SAMPLE_BITS'($urandom);
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
  endtask

  // present one item from a falling edge until it is taken
  task automatic drive_item(input logic [ADL_SAMPLE_BITS-1:0] s, input range_result_t want);
    in_valid  <= 1'b1;
    in_sample <= s;
    @(posedge clk);
    while (in_stall !== 1'b0)
      @(posedge clk);
    pending_ranges.push_back(want);
    sent_count++;
    @(negedge clk);
  endtask

  // receiver back-pressure, switching at random between none, random and heavy modes
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 2));
      stall_left = $urandom_range(50, 300);
    end else begin
      stall_left--;
    end
    stall_phase++;
    case (stall_mode)
      STALL_NONE:   out_stall <= 1'b0;
      STALL_RANDOM: out_stall <= 1'($urandom_range(0, 1));
      default:      out_stall <= (stall_phase % 23) < 17;
    endcase
  end

  // result checker
  always @(posedge clk) begin
    range_result_t want;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (pending_ranges.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("unexpected item: distance %0d out_of_range %0d",
                   out_distance_mm, out_out_of_range);
      end else begin
        want = pending_ranges.pop_front();
        if (want.oor)
          far_count++;
        else if (want.dist_mm == CAL_MM[0])
          near_count++;
        else
          interp_count++;
        if (out_distance_mm !== want.dist_mm || out_out_of_range !== want.oor) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("mismatch: distance exp %0d got %0d, out_of_range exp %0d got %0d",
                     want.dist_mm, out_distance_mm, want.oor, out_out_of_range);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout: %0d items sent, %0d results outstanding",
               sent_count, pending_ranges.size());
      $display("tb: failure");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    range_result_t              want;
    logic [ADL_SAMPLE_BITS-1:0] s;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed sweep over codes and range limits
    for (int i = 0; i < PROBE_COUNT; i++) begin
      pace_sender();
      if (PROBE_ROWS[i].fixed) begin
        want.dist_mm = PROBE_ROWS[i].dist_mm;
        want.oor     = PROBE_ROWS[i].oor;
      end else begin
        want = predict_range(PROBE_ROWS[i].sample);
      end
      drive_item(PROBE_ROWS[i].sample, want);
    end

    // random samples
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pace_sender();
      s = pick_sample();
      drive_item(s, predict_range(s));
    end
    in_valid <= 1'b0;

    while (pending_ranges.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d samples converted in %0d cycles: %0d near field, %0d interpolated,",
             sent_count, cycle_count, near_count, interp_count);
    $display("%0d beyond range, %0d failures", far_count, fail_count);
    if (fail_count == 0 && pending_ranges.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
